// File: src/sms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sms_pkg;

    // Item kinds on the input stream.
    localparam logic [1:0] OPC_WRITE   = 2'd0;
    localparam logic [1:0] OPC_EXEC    = 2'd1;
    localparam logic [1:0] OPC_RESTART = 2'd2;

    // Result status codes.
    localparam logic [3:0] ST_OK    = 4'd0;
    localparam logic [3:0] ST_PNUM  = 4'd1;
    localparam logic [3:0] ST_PCHR  = 4'd2;
    localparam logic [3:0] ST_HALT  = 4'd3;
    localparam logic [3:0] ST_UNDER = 4'd4;
    localparam logic [3:0] ST_OVER  = 4'd5;
    localparam logic [3:0] ST_DIVZ  = 4'd6;
    localparam logic [3:0] ST_UNK   = 4'd7;
    localparam logic [3:0] ST_WROTE = 4'd8;

    // Instruction codes.
    localparam logic [15:0] I_ADD     = 16'd0;
    localparam logic [15:0] I_ADD_RAM = 16'd1;
    localparam logic [15:0] I_AFS     = 16'd2;
    localparam logic [15:0] I_ASC     = 16'd3;
    localparam logic [15:0] I_BEQ     = 16'd4;
    localparam logic [15:0] I_BNE     = 16'd5;
    localparam logic [15:0] I_DFS     = 16'd6;
    localparam logic [15:0] I_DIV     = 16'd7;
    localparam logic [15:0] I_DIV_RAM = 16'd8;
    localparam logic [15:0] I_DONE    = 16'd9;
    localparam logic [15:0] I_DUP     = 16'd10;
    localparam logic [15:0] I_JEQ     = 16'd11;
    localparam logic [15:0] I_JNE     = 16'd12;
    localparam logic [15:0] I_JUMP    = 16'd13;
    localparam logic [15:0] I_MOD     = 16'd14;
    localparam logic [15:0] I_MOD_RAM = 16'd15;
    localparam logic [15:0] I_MFS     = 16'd16;
    localparam logic [15:0] I_MUL     = 16'd17;
    localparam logic [15:0] I_MUL_RAM = 16'd18;
    localparam logic [15:0] I_POP     = 16'd19;
    localparam logic [15:0] I_PRINT   = 16'd20;
    localparam logic [15:0] I_PEEK    = 16'd21;
    localparam logic [15:0] I_POKE    = 16'd22;
    localparam logic [15:0] I_PUSH    = 16'd23;
    localparam logic [15:0] I_RFS     = 16'd24;
    localparam logic [15:0] I_SFS     = 16'd25;
    localparam logic [15:0] I_STACK   = 16'd26;
    localparam logic [15:0] I_SUB     = 16'd27;
    localparam logic [15:0] I_SUB_RAM = 16'd28;
    // Shell call: not provided, reported as an unknown code.
    localparam logic [15:0] I_SYS     = 16'd29;

    // Arithmetic operation selected by the decoder.
    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_MOD
    } alu_op_t;

    // Decoded instruction properties.
    typedef struct packed {
        alu_op_t alu;
        logic    two;
        logic    use_ind;
    } dec_t;

    function automatic dec_t decode(input logic [15:0] w);
        dec_t d;
        d = '{alu: ALU_NONE, two: 1'b0, use_ind: 1'b0};
        unique case (w)
            I_ADD:     d.alu = ALU_ADD;
            I_ADD_RAM: d = '{alu: ALU_ADD, two: 1'b0, use_ind: 1'b1};
            I_AFS:     d = '{alu: ALU_ADD, two: 1'b1, use_ind: 1'b0};
            I_DFS:     d = '{alu: ALU_DIV, two: 1'b1, use_ind: 1'b0};
            I_DIV:     d.alu = ALU_DIV;
            I_DIV_RAM: d = '{alu: ALU_DIV, two: 1'b0, use_ind: 1'b1};
            I_MOD:     d.alu = ALU_MOD;
            I_MOD_RAM: d = '{alu: ALU_MOD, two: 1'b0, use_ind: 1'b1};
            I_MFS:     d = '{alu: ALU_MUL, two: 1'b1, use_ind: 1'b0};
            I_MUL:     d.alu = ALU_MUL;
            I_MUL_RAM: d = '{alu: ALU_MUL, two: 1'b0, use_ind: 1'b1};
            I_RFS:     d = '{alu: ALU_MOD, two: 1'b1, use_ind: 1'b0};
            I_SFS:     d = '{alu: ALU_SUB, two: 1'b1, use_ind: 1'b0};
            I_SUB:     d.alu = ALU_SUB;
            I_SUB_RAM: d = '{alu: ALU_SUB, two: 1'b0, use_ind: 1'b1};
            default:   d = '{alu: ALU_NONE, two: 1'b0, use_ind: 1'b0};
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// File: src/stack_machine_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Contents
// s_axis    in         tdata = {data, address}, tuser = opcode
// m_axis    out        tdata = {pc, value}, tuser = status
//
// One item at a time. A write, an unused opcode or an execute on a stopped
// machine goes straight to S_OUT for its result. An instruction first reads
// the program memory port for the code, the operand and the indirect word in
// turn, then reads the stack top and second entry from the stack memory. DIV
// and MOD then run the bit-serial divider. Restart clears the stack with a
// sweep over all STACK_DEPTH entries before its result is given; the same
// sweep runs after reset, during which no item is taken. A held result stalls
// the block until it is taken.

module stack_machine_step #(
    parameter int MEM_DEPTH   = 4096,
    parameter int STACK_DEPTH = 256
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // address[15:0], data[31:16]
    input  wire  [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value[15:0], pc[31:16]
    output logic [3:0]  m_axis_tuser    // status[3:0]
);

    localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SDW = SAW + 1;
    localparam logic [SDW-1:0] SFULL = SDW'(STACK_DEPTH);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RDW   = 4'd2;
    localparam logic [3:0] S_RDX   = 4'd3;
    localparam logic [3:0] S_RDI   = 4'd4;
    localparam logic [3:0] S_RDS   = 4'd5;
    localparam logic [3:0] S_EXEC  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DFIN  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    // Memories.
    logic [15:0] pmem [MEM_DEPTH];
    logic [15:0] smem [STACK_DEPTH];

    logic [3:0]     state_reg, state_next;
    logic [15:0]    pc_reg, pc_next;
    logic [SDW-1:0] sp_reg, sp_next;
    logic           stop_reg, stop_next;
    logic [SDW-1:0] clr_reg, clr_next;
    logic           boot_reg, boot_next;

    logic [15:0] w_reg, x_reg, ind_reg, top_reg, sec_reg;
    logic [15:0] w_next, x_next, ind_next, top_next, sec_next;

    // Divider state: magnitudes, remainder and quotient.
    logic [15:0] dvd_reg, dvd_next, dvs_reg, dvs_next, rem_reg, rem_next;
    logic [4:0]  dcnt_reg, dcnt_next;
    logic        qneg_reg, qneg_next, rneg_reg, rneg_next, dmod_reg, dmod_next;

    logic        ov_reg, ov_next;
    logic [3:0]  ost_reg, ost_next;
    logic [15:0] oval_reg, oval_next, opc_reg, opc_next;

    // Memory port controls.
    logic           pm_we;
    logic [MAW-1:0] pm_wa, pm_ra;
    logic [15:0]    pm_wd, pm_rd;
    logic           sm_we;
    logic [SAW-1:0] sm_wa, sm_ra;
    logic [15:0]    sm_wd, sm_rd;

    logic        in_fire;
    logic [1:0]  in_opc;
    logic [15:0] in_addr, in_data;

    assign in_opc  = s_axis_tuser;
    assign in_addr = s_axis_tdata[15:0];
    assign in_data = s_axis_tdata[31:16];
    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {opc_reg, oval_reg};
    assign m_axis_tuser  = ost_reg;

    // Program memory: one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            pmem[pm_wa] <= pm_wd;
        end
        pm_rd <= pmem[pm_ra];
    end

    // Stack memory: one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            smem[sm_wa] <= sm_wd;
        end
        sm_rd <= smem[sm_ra];
    end

    // Arithmetic helpers.
    sms_pkg::dec_t dec;
    logic [15:0]   opb, alu_res, mul_res;
    logic [31:0]   mul_full;
    logic [15:0]   abs_a, abs_b;
    logic [16:0]   rtrial;
    logic [15:0]   rshift;
    logic [15:0]   q_fix, r_fix;

    assign dec      = sms_pkg::decode(w_reg);
    assign opb      = dec.two ? top_reg : (dec.use_ind ? ind_reg : x_reg);
    assign mul_full = (dec.two ? sec_reg : top_reg) * opb;
    assign mul_res  = mul_full[15:0];
    assign abs_a    = (dec.two ? sec_reg : top_reg);
    assign abs_b    = opb;
    assign rshift   = {rem_reg[14:0], dvd_reg[15]};
    assign rtrial   = {1'b0, rshift} - {1'b0, dvs_reg};
    assign q_fix    = qneg_reg ? (16'd0 - dvd_reg) : dvd_reg;
    assign r_fix    = rneg_reg ? (16'd0 - rem_reg) : rem_reg;

    always_comb
    begin
        unique case (dec.alu)
            sms_pkg::ALU_ADD: alu_res = abs_a + opb;
            sms_pkg::ALU_SUB: alu_res = abs_a - opb;
            sms_pkg::ALU_MUL: alu_res = mul_res;
            default:          alu_res = 16'd0;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        sp_next    = sp_reg;
        stop_next  = stop_reg;
        clr_next   = clr_reg;
        boot_next  = boot_reg;
        w_next     = w_reg;
        x_next     = x_reg;
        ind_next   = ind_reg;
        top_next   = top_reg;
        sec_next   = sec_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        qneg_next  = qneg_reg;
        rneg_next  = rneg_reg;
        dmod_next  = dmod_reg;
        ov_next    = ov_reg;
        ost_next   = ost_reg;
        oval_next  = oval_reg;
        opc_next   = opc_reg;
        pm_we = 1'b0;
        pm_wa = in_addr[MAW-1:0];
        pm_wd = in_data;
        pm_ra = pc_reg[MAW-1:0];
        sm_we = 1'b0;
        sm_wa = clr_reg[SAW-1:0];
        sm_wd = 16'd0;
        sm_ra = SAW'(sp_reg - SDW'(1));

        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                sm_we = 1'b1;
                clr_next = clr_reg + SDW'(1);
                if (clr_reg == SFULL - SDW'(1))
                begin
                    // The power-up sweep produces no transaction.
                    boot_next = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_OUT;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    oval_next = 16'd0;
                    unique case (in_opc)
                        sms_pkg::OPC_WRITE:
                        begin
                            pm_we = 1'b1;
                            ost_next = sms_pkg::ST_WROTE;
                            state_next = S_OUT;
                        end
                        sms_pkg::OPC_EXEC:
                        begin
                            if (stop_reg)
                            begin
                                ost_next = sms_pkg::ST_HALT;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                pm_ra = pc_reg[MAW-1:0];
                                state_next = S_RDW;
                            end
                        end
                        sms_pkg::OPC_RESTART:
                        begin
                            ost_next = sms_pkg::ST_OK;
                            pc_next = 16'd0;
                            sp_next = '0;
                            stop_next = 1'b0;
                            clr_next = '0;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            ost_next = sms_pkg::ST_OK;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_RDW:
            begin
                w_next = pm_rd;
                pm_ra = MAW'(pc_reg + 16'd1);
                state_next = S_RDX;
            end
            S_RDX:
            begin
                x_next = pm_rd;
                pm_ra = pm_rd[MAW-1:0];
                sm_ra = SAW'(sp_reg - SDW'(1));
                state_next = S_RDI;
            end
            S_RDI:
            begin
                ind_next = pm_rd;
                top_next = sm_rd;
                sm_ra = SAW'(sp_reg - SDW'(2));
                state_next = S_RDS;
            end
            S_RDS:
            begin
                sec_next = sm_rd;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                ost_next = sms_pkg::ST_OK;
                state_next = S_OUT;
                if (dec.alu != sms_pkg::ALU_NONE)
                begin
                    if (sp_reg < (dec.two ? SDW'(2) : SDW'(1)))
                    begin
                        ost_next = sms_pkg::ST_UNDER;
                        stop_next = 1'b1;
                    end
                    else if ((dec.alu == sms_pkg::ALU_DIV || dec.alu == sms_pkg::ALU_MOD)
                             && opb == 16'd0)
                    begin
                        ost_next = sms_pkg::ST_DIVZ;
                        stop_next = 1'b1;
                    end
                    else if (dec.alu == sms_pkg::ALU_DIV || dec.alu == sms_pkg::ALU_MOD)
                    begin
                        dvd_next  = abs_a[15] ? 16'd0 - abs_a : abs_a;
                        dvs_next  = abs_b[15] ? 16'd0 - abs_b : abs_b;
                        rem_next  = 16'd0;
                        dcnt_next = 5'd0;
                        qneg_next = abs_a[15] ^ abs_b[15];
                        rneg_next = abs_a[15];
                        dmod_next = (dec.alu == sms_pkg::ALU_MOD);
                        state_next = S_DIV;
                    end
                    else
                    begin
                        sm_we = 1'b1;
                        sm_wd = alu_res;
                        if (dec.two)
                        begin
                            sm_wa = SAW'(sp_reg - SDW'(2));
                            sp_next = sp_reg - SDW'(1);
                            pc_next = pc_reg + 16'd1;
                        end
                        else
                        begin
                            sm_wa = SAW'(sp_reg - SDW'(1));
                            pc_next = pc_reg + 16'd2;
                        end
                    end
                end
                else
                begin
                    priority case (1'b1)
                        (w_reg == sms_pkg::I_ASC || w_reg == sms_pkg::I_PRINT):
                        begin
                            if (sp_reg == '0)
                            begin
                                ost_next = sms_pkg::ST_UNDER;
                                stop_next = 1'b1;
                            end
                            else
                            begin
                                pc_next = pc_reg + 16'd1;
                                oval_next = top_reg;
                                ost_next = (w_reg == sms_pkg::I_ASC) ? sms_pkg::ST_PCHR
                                                                     : sms_pkg::ST_PNUM;
                            end
                        end
                        (w_reg == sms_pkg::I_BEQ || w_reg == sms_pkg::I_BNE):
                        begin
                            if (sp_reg == '0)
                            begin
                                ost_next = sms_pkg::ST_UNDER;
                                stop_next = 1'b1;
                            end
                            else if ((top_reg == 16'd0) == (w_reg == sms_pkg::I_BEQ))
                            begin
                                pc_next = pc_reg + 16'd1 + x_reg;
                            end
                            else
                            begin
                                pc_next = pc_reg + 16'd2;
                            end
                        end
                        (w_reg == sms_pkg::I_JEQ || w_reg == sms_pkg::I_JNE):
                        begin
                            if (sp_reg == '0)
                            begin
                                ost_next = sms_pkg::ST_UNDER;
                                stop_next = 1'b1;
                            end
                            else if ((top_reg == 16'd0) == (w_reg == sms_pkg::I_JEQ))
                            begin
                                pc_next = x_reg;
                            end
                            else
                            begin
                                pc_next = pc_reg + 16'd2;
                            end
                        end
                        (w_reg == sms_pkg::I_DONE):
                        begin
                            ost_next = sms_pkg::ST_HALT;
                            stop_next = 1'b1;
                        end
                        (w_reg == sms_pkg::I_DUP):
                        begin
                            if (sp_reg == '0)
                            begin
                                ost_next = sms_pkg::ST_UNDER;
                                stop_next = 1'b1;
                            end
                            else if (sp_reg >= SFULL)
                            begin
                                ost_next = sms_pkg::ST_OVER;
                                stop_next = 1'b1;
                            end
                            else
                            begin
                                sm_we = 1'b1;
                                sm_wa = sp_reg[SAW-1:0];
                                sm_wd = top_reg;
                                sp_next = sp_reg + SDW'(1);
                                pc_next = pc_reg + 16'd1;
                            end
                        end
                        (w_reg == sms_pkg::I_JUMP):
                        begin
                            pc_next = x_reg;
                        end
                        (w_reg == sms_pkg::I_POP):
                        begin
                            if (sp_reg == '0)
                            begin
                                ost_next = sms_pkg::ST_UNDER;
                                stop_next = 1'b1;
                            end
                            else
                            begin
                                sm_we = 1'b1;
                                sm_wa = SAW'(sp_reg - SDW'(1));
                                sp_next = sp_reg - SDW'(1);
                                pc_next = pc_reg + 16'd1;
                            end
                        end
                        (w_reg == sms_pkg::I_PEEK || w_reg == sms_pkg::I_PUSH):
                        begin
                            if (sp_reg >= SFULL)
                            begin
                                ost_next = sms_pkg::ST_OVER;
                                stop_next = 1'b1;
                            end
                            else
                            begin
                                sm_we = 1'b1;
                                sm_wa = sp_reg[SAW-1:0];
                                sm_wd = (w_reg == sms_pkg::I_PEEK) ? ind_reg : x_reg;
                                sp_next = sp_reg + SDW'(1);
                                pc_next = pc_reg + 16'd2;
                            end
                        end
                        (w_reg == sms_pkg::I_POKE):
                        begin
                            if (sp_reg == '0)
                            begin
                                ost_next = sms_pkg::ST_UNDER;
                                stop_next = 1'b1;
                            end
                            else
                            begin
                                pm_we = 1'b1;
                                pm_wa = x_reg[MAW-1:0];
                                pm_wd = top_reg;
                                sm_we = 1'b1;
                                sm_wa = SAW'(sp_reg - SDW'(1));
                                sp_next = sp_reg - SDW'(1);
                                pc_next = pc_reg + 16'd2;
                            end
                        end
                        (w_reg == sms_pkg::I_STACK):
                        begin
                            pc_next = pc_reg + 16'd1;
                        end
                        default:
                        begin
                            ost_next = sms_pkg::ST_UNK;
                            oval_next = w_reg;
                            stop_next = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                // One restoring step: quotient bits shift into dvd_reg.
                if (!rtrial[16])
                begin
                    rem_next = rtrial[15:0];
                end
                else
                begin
                    rem_next = rshift;
                end
                dvd_next = {dvd_reg[14:0], !rtrial[16]};
                dcnt_next = dcnt_reg + 5'd1;
                if (dcnt_reg == 5'd15)
                begin
                    state_next = S_DFIN;
                end
            end
            S_DFIN:
            begin
                sm_we = 1'b1;
                sm_wd = dmod_reg ? r_fix : q_fix;
                if (dec.two)
                begin
                    sm_wa = SAW'(sp_reg - SDW'(2));
                    sp_next = sp_reg - SDW'(1);
                    pc_next = pc_reg + 16'd1;
                end
                else
                begin
                    sm_wa = SAW'(sp_reg - SDW'(1));
                    pc_next = pc_reg + 16'd2;
                end
                ost_next = sms_pkg::ST_OK;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                ov_next = 1'b1;
                opc_next = pc_next;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pc_reg    <= 16'd0;
            sp_reg    <= '0;
            stop_reg  <= 1'b0;
            clr_reg   <= '0;
            boot_reg  <= 1'b1;
            ov_reg    <= 1'b0;
            dcnt_reg  <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            sp_reg    <= sp_next;
            stop_reg  <= stop_next;
            clr_reg   <= clr_next;
            boot_reg  <= boot_next;
            ov_reg    <= ov_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        x_reg    <= x_next;
        ind_reg  <= ind_next;
        top_reg  <= top_next;
        sec_reg  <= sec_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
        dmod_reg <= dmod_next;
        ost_reg  <= ost_next;
        oval_reg <= oval_next;
        opc_reg  <= opc_next;
    end

`ifndef SYNTHESIS
    // The stack never holds more entries than its depth.
    assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= SFULL)
        else $error("stack depth out of range");

    // No input is taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n) m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken with result pending");

    // A taken result is not shown again in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("result repeated");
`endif

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int MEM_WORDS    = 4096;
    localparam int STACK_WORDS  = 256;
    localparam int RANDOM_ITEMS = 150;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int HOLD_CYCLES  = 300;

    // Machine state tracker and result checker.
    class sm_scoreboard;
        logic [15:0] mem [MEM_WORDS];
        bit          written [MEM_WORDS];
        logic [15:0] stk [STACK_WORDS];
        int          depth;
        logic [15:0] pc;
        bit          stopped;
        logic [3:0]  want_status [$];
        logic [15:0] want_value [$];
        logic [15:0] want_pc [$];
        int          errors;

        function new();
            foreach (mem[i]) mem[i] = '0;
            foreach (written[i]) written[i] = 1'b0;
            clear_machine();
            errors = 0;
        endfunction

        function void clear_machine();
            foreach (stk[i]) stk[i] = '0;
            depth = 0;
            pc = '0;
            stopped = 1'b0;
        endfunction

        function void post(logic [3:0] st, logic [15:0] val);
            want_status.push_back(st);
            want_value.push_back(val);
            want_pc.push_back(pc);
        endfunction

        function void halt_with(logic [3:0] st, logic [15:0] val);
            stopped = 1'b1;
            post(st, val);
        endfunction

        // Returns zero when the divisor is zero.
        function bit arith(sms_pkg::alu_op_t op, logic [15:0] a, logic [15:0] b,
                           output logic [15:0] r);
            int sa;
            int sb;
            sa = $signed(a);
            sb = $signed(b);
            r = '0;
            case (op)
                sms_pkg::ALU_ADD: r = a + b;
                sms_pkg::ALU_SUB: r = a - b;
                sms_pkg::ALU_MUL: r = a * b;
                sms_pkg::ALU_DIV:
                begin
                    if (sb == 0) return 1'b0;
                    r = 16'(sa / sb);
                end
                default:
                begin
                    if (sb == 0) return 1'b0;
                    r = 16'(sa % sb);
                end
            endcase
            return 1'b1;
        endfunction

        function void run_instruction();
            logic [15:0]      w;
            logic [15:0]      x;
            logic [15:0]      ind;
            logic [15:0]      top;
            logic [15:0]      b;
            logic [15:0]      r;
            sms_pkg::alu_op_t op;
            bit               two;
            w = mem[pc[11:0]];
            x = mem[16'(pc + 16'd1) % MEM_WORDS];
            ind = mem[x[11:0]];
            top = (depth > 0) ? stk[depth - 1] : 16'd0;
            op = sms_pkg::ALU_NONE;
            two = 1'b0;
            b = '0;
            if (stopped)
            begin
                post(sms_pkg::ST_HALT, 16'd0);
                return;
            end
            case (w)
                sms_pkg::I_ADD:     begin op = sms_pkg::ALU_ADD; b = x; end
                sms_pkg::I_ADD_RAM: begin op = sms_pkg::ALU_ADD; b = ind; end
                sms_pkg::I_AFS:     begin op = sms_pkg::ALU_ADD; two = 1'b1; end
                sms_pkg::I_DFS:     begin op = sms_pkg::ALU_DIV; two = 1'b1; end
                sms_pkg::I_DIV:     begin op = sms_pkg::ALU_DIV; b = x; end
                sms_pkg::I_DIV_RAM: begin op = sms_pkg::ALU_DIV; b = ind; end
                sms_pkg::I_MOD:     begin op = sms_pkg::ALU_MOD; b = x; end
                sms_pkg::I_MOD_RAM: begin op = sms_pkg::ALU_MOD; b = ind; end
                sms_pkg::I_MFS:     begin op = sms_pkg::ALU_MUL; two = 1'b1; end
                sms_pkg::I_MUL:     begin op = sms_pkg::ALU_MUL; b = x; end
                sms_pkg::I_MUL_RAM: begin op = sms_pkg::ALU_MUL; b = ind; end
                sms_pkg::I_RFS:     begin op = sms_pkg::ALU_MOD; two = 1'b1; end
                sms_pkg::I_SFS:     begin op = sms_pkg::ALU_SUB; two = 1'b1; end
                sms_pkg::I_SUB:     begin op = sms_pkg::ALU_SUB; b = x; end
                sms_pkg::I_SUB_RAM: begin op = sms_pkg::ALU_SUB; b = ind; end
                default:            op = sms_pkg::ALU_NONE;
            endcase

            // Arithmetic forms: immediate, memory-indirect and from-stack.
            if (op != sms_pkg::ALU_NONE)
            begin
                if (depth < (two ? 2 : 1))
                begin
                    halt_with(sms_pkg::ST_UNDER, 16'd0);
                    return;
                end
                if (two)
                begin
                    if (!arith(op, stk[depth - 2], top, r))
                    begin
                        halt_with(sms_pkg::ST_DIVZ, 16'd0);
                        return;
                    end
                    depth--;
                    stk[depth] = '0;
                    stk[depth - 1] = r;
                    pc = pc + 16'd1;
                end
                else
                begin
                    if (!arith(op, top, b, r))
                    begin
                        halt_with(sms_pkg::ST_DIVZ, 16'd0);
                        return;
                    end
                    stk[depth - 1] = r;
                    pc = pc + 16'd2;
                end
                post(sms_pkg::ST_OK, 16'd0);
                return;
            end

            case (w)
                sms_pkg::I_ASC, sms_pkg::I_PRINT:
                begin
                    if (depth == 0) begin halt_with(sms_pkg::ST_UNDER, 16'd0); return; end
                    pc = pc + 16'd1;
                    post((w == sms_pkg::I_ASC) ? sms_pkg::ST_PCHR : sms_pkg::ST_PNUM, top);
                end
                sms_pkg::I_BEQ, sms_pkg::I_BNE:
                begin
                    if (depth == 0) begin halt_with(sms_pkg::ST_UNDER, 16'd0); return; end
                    if ((top == 16'd0) == (w == sms_pkg::I_BEQ))
                        pc = pc + 16'd1 + x;
                    else
                        pc = pc + 16'd2;
                    post(sms_pkg::ST_OK, 16'd0);
                end
                sms_pkg::I_JEQ, sms_pkg::I_JNE:
                begin
                    if (depth == 0) begin halt_with(sms_pkg::ST_UNDER, 16'd0); return; end
                    if ((top == 16'd0) == (w == sms_pkg::I_JEQ))
                        pc = x;
                    else
                        pc = pc + 16'd2;
                    post(sms_pkg::ST_OK, 16'd0);
                end
                sms_pkg::I_DONE:
                    halt_with(sms_pkg::ST_HALT, 16'd0);
                sms_pkg::I_DUP:
                begin
                    if (depth == 0) begin halt_with(sms_pkg::ST_UNDER, 16'd0); return; end
                    if (depth >= STACK_WORDS)
                    begin
                        halt_with(sms_pkg::ST_OVER, 16'd0);
                        return;
                    end
                    stk[depth] = top;
                    depth++;
                    pc = pc + 16'd1;
                    post(sms_pkg::ST_OK, 16'd0);
                end
                sms_pkg::I_JUMP:
                begin
                    pc = x;
                    post(sms_pkg::ST_OK, 16'd0);
                end
                sms_pkg::I_POP:
                begin
                    if (depth == 0) begin halt_with(sms_pkg::ST_UNDER, 16'd0); return; end
                    depth--;
                    stk[depth] = '0;
                    pc = pc + 16'd1;
                    post(sms_pkg::ST_OK, 16'd0);
                end
                sms_pkg::I_PEEK, sms_pkg::I_PUSH:
                begin
                    if (depth >= STACK_WORDS)
                    begin
                        halt_with(sms_pkg::ST_OVER, 16'd0);
                        return;
                    end
                    stk[depth] = (w == sms_pkg::I_PEEK) ? ind : x;
                    depth++;
                    pc = pc + 16'd2;
                    post(sms_pkg::ST_OK, 16'd0);
                end
                sms_pkg::I_POKE:
                begin
                    if (depth == 0) begin halt_with(sms_pkg::ST_UNDER, 16'd0); return; end
                    mem[x[11:0]] = top;
                    written[x[11:0]] = 1'b1;
                    depth--;
                    stk[depth] = '0;
                    pc = pc + 16'd2;
                    post(sms_pkg::ST_OK, 16'd0);
                end
                sms_pkg::I_STACK:
                begin
                    pc = pc + 16'd1;
                    post(sms_pkg::ST_OK, 16'd0);
                end
                default:
                    halt_with(sms_pkg::ST_UNK, w);
            endcase
        endfunction

        // Update the machine for one accepted input transaction.
        function void note(logic [1:0] opc, logic [15:0] addr, logic [15:0] data);
            case (opc)
                sms_pkg::OPC_WRITE:
                begin
                    mem[addr[11:0]] = data;
                    written[addr[11:0]] = 1'b1;
                    post(sms_pkg::ST_WROTE, 16'd0);
                end
                sms_pkg::OPC_EXEC:
                    run_instruction();
                sms_pkg::OPC_RESTART:
                begin
                    clear_machine();
                    post(sms_pkg::ST_OK, 16'd0);
                end
                default:
                    post(sms_pkg::ST_OK, 16'd0);
            endcase
        endfunction

        // Compare one output transaction with the oldest expected result.
        function void check(logic [3:0] st, logic [15:0] val, logic [15:0] p);
            logic [3:0]  es;
            logic [15:0] ev;
            logic [15:0] ep;
            if (want_status.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d value %h pc %h", st, val, p);
                return;
            end
            es = want_status.pop_front();
            ev = want_value.pop_front();
            ep = want_pc.pop_front();
            if (st !== es || val !== ev || p !== ep)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: status %0d/%0d value %h/%h pc %h/%h (expected/actual)",
                             es, st, ev, val, ep, p);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;

    sm_scoreboard sb;
    int           sent;
    int           target;
    int           cycles;
    bit           quiet;
    bit           hold_req;
    bit           hold_done;

    stack_machine_step dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    always #2 clk = ~clk;

    // Cycle counter with a hard limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16]);
    end

    // Receiver: random stalls, one long hold-off, none at the end.
    initial
    begin
        int idle_left;
        idle_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                idle_left = $urandom_range(1, 4) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Offer one transaction, with an occasional idle burst ahead of it.
    task automatic send_item(logic [1:0] opc, logic [15:0] addr, logic [15:0] data);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, addr};
        s_axis_tuser  <= opc;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note(opc, addr, data);
        sent++;
        if (sent == 150)
            hold_req = 1'b1;
        quiet = (target > 0) && (sent >= target - 60);
    endtask

    function automatic logic [15:0] pick_instruction();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28) return sms_pkg::I_PUSH;
        if (r < 36) return sms_pkg::I_DUP;
        if (r < 38) return sms_pkg::I_SYS;
        if (r < 40) return 16'($urandom_range(30, 65535));
        return 16'($urandom_range(0, 28));
    endfunction

    function automatic logic [15:0] pick_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 16'($urandom_range(0, 40));
        if (r < 55) return 16'h0000;
        if (r < 65) return 16'hFFFF;
        if (r < 70) return 16'h8000;
        if (r < 75) return 16'h7FFF;
        return 16'($urandom);
    endfunction

    // Write a word only where memory has never been written, so that no
    // read of an unwritten word is caused. Upper address bits are random.
    task automatic fill_word(logic [15:0] idx, logic [15:0] val);
        if (!sb.written[idx[11:0]])
            send_item(sms_pkg::OPC_WRITE, {4'($urandom), idx[11:0]}, val);
    endtask

    // Run one instruction after making sure its three memory reads are defined.
    task automatic exec_step(bit fresh);
        logic [15:0] a;
        logic [15:0] x;
        a = sb.pc;
        if (fresh && $urandom_range(0, 99) < 30)
            send_item(sms_pkg::OPC_WRITE, {4'($urandom), a[11:0]}, pick_instruction());
        fill_word(a, pick_instruction());
        fill_word(a + 16'd1, pick_operand());
        x = sb.mem[16'(a + 16'd1) % MEM_WORDS];
        fill_word(x, pick_operand());
        send_item(sms_pkg::OPC_EXEC, 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        int r;
        int n;
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = sms_pkg::OPC_WRITE;
        m_axis_tready = 1'b0;
        sent = 0;
        target = 0;
        cycles = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, quotient overflow, print, zero divisor,
        // stopped machine, underflow and restart.
        send_item(sms_pkg::OPC_WRITE, 16'hFFFF, 16'h7FFF);
        send_item(sms_pkg::OPC_WRITE, 16'h0000, sms_pkg::I_PUSH);
        send_item(sms_pkg::OPC_WRITE, 16'h0001, 16'h8000);
        send_item(sms_pkg::OPC_WRITE, 16'h0002, sms_pkg::I_DIV);
        send_item(sms_pkg::OPC_WRITE, 16'h0003, 16'hFFFF);
        send_item(sms_pkg::OPC_WRITE, 16'h0004, sms_pkg::I_PRINT);
        send_item(sms_pkg::OPC_WRITE, 16'h0005, sms_pkg::I_MOD);
        send_item(sms_pkg::OPC_WRITE, 16'h0006, 16'hFFFF);
        send_item(sms_pkg::OPC_WRITE, 16'h0007, sms_pkg::I_ASC);
        send_item(sms_pkg::OPC_WRITE, 16'h0008, sms_pkg::I_DIV);
        send_item(sms_pkg::OPC_WRITE, 16'h0009, 16'h0000);
        repeat (7) exec_step(1'b0);
        send_item(sms_pkg::OPC_RESTART, 16'hFFFF, 16'hFFFF);
        send_item(sms_pkg::OPC_WRITE, 16'h0000, sms_pkg::I_POP);
        exec_step(1'b0);
        send_item(sms_pkg::OPC_RESTART, 16'h0000, 16'h0000);

        // Stack fill: PUSH, then a DUP / BNE loop until overflow.
        send_item(sms_pkg::OPC_WRITE, 16'h0000, sms_pkg::I_PUSH);
        send_item(sms_pkg::OPC_WRITE, 16'h0001, 16'h8001);
        send_item(sms_pkg::OPC_WRITE, 16'h0002, sms_pkg::I_DUP);
        send_item(sms_pkg::OPC_WRITE, 16'h0003, sms_pkg::I_BNE);
        send_item(sms_pkg::OPC_WRITE, 16'h0004, 16'hFFFE);
        n = 0;
        while (!sb.stopped && n < 700)
        begin
            exec_step(1'b0);
            n++;
        end
        send_item(sms_pkg::OPC_RESTART, 16'h1234, 16'h5678);

        // Random programs, writes and restarts.
        target = sent + RANDOM_ITEMS;
        while (sent < target)
        begin
            r = $urandom_range(0, 99);
            if (sb.stopped && r < 70)
                send_item(sms_pkg::OPC_RESTART, 16'($urandom), 16'($urandom));
            else if (r < 8)
                send_item(sms_pkg::OPC_WRITE, 16'($urandom), 16'($urandom));
            else if (r < 11)
                send_item(sms_pkg::OPC_RESTART, 16'($urandom), 16'($urandom));
            else
                exec_step(1'b1);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.want_status.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// File: sim.f
src/sms_pkg.sv
src/stack_machine_step.sv
sim/testbench.sv
